/* rtl/core/lzfd_pkg.sv */
`default_nettype none
package lzfd_pkg;

  localparam int unsigned LANES = 4;
  localparam logic [23:0] MAX_OUT_RESET = 24'd614400;
  localparam logic [4:0] REFILL_HIGH = 5'd31;

  typedef enum logic [3:0] {
    PH_TYPE = 4'd0,
    PH_KIND = 4'd1,
    PH_LEN1 = 4'd2,
    PH_LEN0 = 4'd3,
    PH_LIT  = 4'd4,
    PH_SOFF = 4'd5,
    PH_LLO  = 4'd6,
    PH_LHI  = 4'd7,
    PH_XLEN = 4'd8,
    PH_DONE = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_END  = 2'd1,
    ST_OVER = 2'd2,
    ST_REF  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_LIT  = 2'd0,
    CMD_COPY = 2'd1,
    CMD_END  = 2'd2
  } cmd_kind_t;

  typedef enum logic [2:0] {
    BK_IDLE  = 3'd0,
    BK_CHECK = 3'd1,
    BK_WRITE = 3'd2,
    BK_EMIT  = 3'd3,
    BK_FLUSH = 3'd4
  } back_state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_of_image;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic [2:0] byte_count;
    logic       last_of_run;
    status_t    status;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        restart;
    logic [7:0]  lit;
    logic [8:0]  len;
    logic [12:0] distance;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/core/lzfd_front.sv */
`default_nettype none
module lzfd_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire lzfd_pkg::in_item_t in_data,
  output logic                    cmd_valid,
  input  wire logic               cmd_ready,
  output lzfd_pkg::cmd_t          cmd
);

  typedef struct packed {
    lzfd_pkg::phase_t phase;
    logic [15:0]      fw;
    logic [4:0]       bits;
    logic [8:0]       plen;
  } pstate_t;

  // consume flag bits while the token still needs them (at most four)
  function automatic pstate_t run_bits(input pstate_t s);
    pstate_t r;
    logic    b;
    r = s;
    for (int i = 0; i < 4; i++) begin
      if (r.phase <= lzfd_pkg::PH_LEN0 && r.bits >= 5'd1 && r.bits <= 5'd16) begin
        b = r.fw[0];
        r.fw = r.fw >> 1;
        r.bits = r.bits - 5'd1;
        unique case (r.phase)
          lzfd_pkg::PH_TYPE: r.phase = b ? lzfd_pkg::PH_LIT : lzfd_pkg::PH_KIND;
          lzfd_pkg::PH_KIND: r.phase = b ? lzfd_pkg::PH_LLO : lzfd_pkg::PH_LEN1;
          lzfd_pkg::PH_LEN1: begin
            r.plen = {7'd0, b, 1'b0};
            r.phase = lzfd_pkg::PH_LEN0;
          end
          default: begin
            r.plen = r.plen + {8'd0, b} + 9'd3;
            r.phase = lzfd_pkg::PH_SOFF;
          end
        endcase
      end
    end
    return r;
  endfunction

  pstate_t     ps, ps_next;
  logic [7:0]  held, held_next;
  logic [12:0] pdist, pdist_next;
  logic        restart_pend, restart_pend_next;
  logic        accept;

  assign in_stall = !cmd_ready;
  assign accept   = in_valid && cmd_ready;

  always_comb begin
    pstate_t    s;
    logic [7:0] b;
    logic       run;
    s = in_data.first_of_image ? pstate_t'{lzfd_pkg::PH_TYPE, 16'd0, 5'd0, 9'd0} : ps;
    b = in_data.in_byte;
    run = 1'b1;
    held_next = in_data.first_of_image ? 8'd0 : held;
    pdist_next = in_data.first_of_image ? 13'd0 : pdist;
    restart_pend_next = restart_pend | in_data.first_of_image;
    cmd_valid = 1'b0;
    cmd = '{lzfd_pkg::CMD_LIT, restart_pend_next, b, 9'd1, 13'd0};
    if (s.phase >= lzfd_pkg::PH_DONE) begin
      run = 1'b0;
    end else if (s.bits == lzfd_pkg::REFILL_HIGH) begin
      s.fw = {b, held_next};
      s.bits = 5'd16;
    end else if (s.bits == 5'd0 || s.bits > 5'd16) begin
      held_next = b;
      s.bits = lzfd_pkg::REFILL_HIGH;
      run = 1'b0;
    end else begin
      priority case (s.phase)
        lzfd_pkg::PH_LIT: begin
          cmd_valid = 1'b1;
          s.phase = lzfd_pkg::PH_TYPE;
        end
        lzfd_pkg::PH_SOFF: begin
          cmd_valid = 1'b1;
          cmd.kind = lzfd_pkg::CMD_COPY;
          cmd.len = s.plen;
          cmd.distance = 13'h100 - {5'd0, b};
          s.phase = lzfd_pkg::PH_TYPE;
        end
        lzfd_pkg::PH_LLO: begin
          held_next = b;
          s.phase = lzfd_pkg::PH_LHI;
        end
        lzfd_pkg::PH_LHI: begin
          pdist_next = 13'h1000 - {1'b0, b[7:4], held_next};
          if (b[3:0] == 4'd0) begin
            s.phase = lzfd_pkg::PH_XLEN;
          end else begin
            cmd_valid = 1'b1;
            cmd.kind = lzfd_pkg::CMD_COPY;
            cmd.len = {5'd0, b[3:0]} + 9'd3;
            cmd.distance = pdist_next;
            s.phase = lzfd_pkg::PH_TYPE;
          end
        end
        lzfd_pkg::PH_XLEN: begin
          cmd_valid = 1'b1;
          if (b == 8'd0) begin
            cmd.kind = lzfd_pkg::CMD_END;
            s.phase = lzfd_pkg::PH_DONE;
            run = 1'b0;
          end else begin
            cmd.kind = lzfd_pkg::CMD_COPY;
            cmd.len = {1'b0, b} + 9'd1;
            cmd.distance = pdist_next;
            s.phase = lzfd_pkg::PH_TYPE;
          end
        end
        default: ;
      endcase
    end
    ps_next = run ? run_bits(s) : s;
    if (cmd_valid) begin
      restart_pend_next = 1'b0;
    end
    cmd_valid = cmd_valid && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ps <= '{lzfd_pkg::PH_TYPE, 16'd0, 5'd0, 9'd0};
      held <= 8'd0;
      pdist <= 13'd0;
      restart_pend <= 1'b0;
    end else if (accept) begin
      ps <= ps_next;
      held <= held_next;
      pdist <= pdist_next;
      restart_pend <= restart_pend_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/lzfd_cmd_queue.sv */
`default_nettype none
module lzfd_cmd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire lzfd_pkg::cmd_t push_cmd,
  output logic                not_full,
  input  wire logic           pop,
  output logic                not_empty,
  output lzfd_pkg::cmd_t      head
);

  lzfd_pkg::cmd_t slots [2];
  logic           wptr, rptr;
  logic [1:0]     fill;

  assign not_full  = fill != 2'd2;
  assign not_empty = fill != 2'd0;
  assign head      = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

/* rtl/core/lzfd_back.sv */
`default_nettype none
module lzfd_back #(
  parameter int unsigned WINDOW_DEPTH = 4096
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [23:0]    max_out,
  input  wire logic           cmd_valid,
  output logic                cmd_pop,
  input  wire lzfd_pkg::cmd_t cmd,
  output logic                out_valid,
  input  wire logic           out_stall,
  output lzfd_pkg::out_item_t out_data
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  logic [7:0] hist [WINDOW_DEPTH];
  logic [7:0] rdata;
  logic [AW-1:0] raddr;
  logic          we;
  logic [7:0]    wbyte;

  lzfd_pkg::back_state_t state, state_next;
  logic [8:0]  rem, rem_next;
  logic [12:0] offs, offs_next;
  logic [7:0]  lit, lit_next;
  logic        is_copy, is_copy_next;
  logic [23:0] bw, bw_next;
  logic [AW-1:0] wp, wp_next;
  logic        done, done_next;
  logic [7:0]  lane [lzfd_pkg::LANES];
  logic [2:0]  n, n_next;
  lzfd_pkg::status_t stat, stat_next;
  logic        load;
  lzfd_pkg::out_item_t load_item;
  logic        slot_free;

  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    logic [AW:0] wide;
    wide = {1'b0, wp} - (AW+1)'(offs);
    if ({1'b0, wp} < (AW+1)'(offs)) begin
      wide = wide + (AW+1)'(WINDOW_DEPTH);
    end
    raddr = wide[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      hist[wp] <= wbyte;
    end
    rdata <= hist[raddr];
  end

  always_comb begin
    logic eff_done;
    state_next = state;
    rem_next = rem;
    offs_next = offs;
    lit_next = lit;
    is_copy_next = is_copy;
    bw_next = bw;
    wp_next = wp;
    done_next = done;
    n_next = n;
    stat_next = stat;
    cmd_pop = 1'b0;
    we = 1'b0;
    wbyte = is_copy ? rdata : lit;
    load = 1'b0;
    eff_done = done;
    load_item.out_byte0 = (n > 3'd0) ? lane[0] : 8'd0;
    load_item.out_byte1 = (n > 3'd1) ? lane[1] : 8'd0;
    load_item.out_byte2 = (n > 3'd2) ? lane[2] : 8'd0;
    load_item.out_byte3 = (n > 3'd3) ? lane[3] : 8'd0;
    load_item.byte_count = n;
    load_item.last_of_run = (rem == 9'd0);
    load_item.status = lzfd_pkg::ST_DATA;
    unique case (state)
      lzfd_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.restart) begin
            bw_next = 24'd0;
            wp_next = '0;
            done_next = 1'b0;
            eff_done = 1'b0;
          end
          if (!eff_done) begin
            unique case (cmd.kind)
              lzfd_pkg::CMD_END: begin
                stat_next = lzfd_pkg::ST_END;
                state_next = lzfd_pkg::BK_FLUSH;
              end
              lzfd_pkg::CMD_COPY: begin
                rem_next = cmd.len;
                offs_next = cmd.distance;
                is_copy_next = 1'b1;
                state_next = lzfd_pkg::BK_CHECK;
              end
              default: begin
                rem_next = 9'd1;
                offs_next = 13'd0;
                lit_next = cmd.lit;
                is_copy_next = 1'b0;
                state_next = lzfd_pkg::BK_CHECK;
              end
            endcase
          end
        end
      end
      lzfd_pkg::BK_CHECK: begin
        if (bw >= max_out) begin
          stat_next = lzfd_pkg::ST_OVER;
          state_next = lzfd_pkg::BK_FLUSH;
        end else if (bw < 24'(offs)) begin
          stat_next = lzfd_pkg::ST_REF;
          state_next = lzfd_pkg::BK_FLUSH;
        end else begin
          state_next = lzfd_pkg::BK_WRITE;
        end
      end
      lzfd_pkg::BK_WRITE: begin
        we = 1'b1;
        n_next = n + 3'd1;
        bw_next = bw + 24'd1;
        wp_next = (wp == AW'(WINDOW_DEPTH - 1)) ? '0 : wp + AW'(1);
        rem_next = rem - 9'd1;
        state_next = (n_next == 3'(lzfd_pkg::LANES) || rem_next == 9'd0) ?
                     lzfd_pkg::BK_EMIT : lzfd_pkg::BK_CHECK;
      end
      lzfd_pkg::BK_EMIT: begin
        if (slot_free) begin
          load = 1'b1;
          n_next = 3'd0;
          state_next = (rem == 9'd0) ? lzfd_pkg::BK_IDLE : lzfd_pkg::BK_CHECK;
        end
      end
      lzfd_pkg::BK_FLUSH: begin
        load_item.last_of_run = 1'b1;
        load_item.status = stat;
        if (slot_free) begin
          load = 1'b1;
          n_next = 3'd0;
          done_next = 1'b1;
          state_next = lzfd_pkg::BK_IDLE;
        end
      end
      default: state_next = lzfd_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      lane[n[1:0]] <= wbyte;
    end
    if (load) begin
      out_data <= load_item;
    end
    rem <= rem_next;
    offs <= offs_next;
    lit <= lit_next;
    is_copy <= is_copy_next;
    stat <= stat_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzfd_pkg::BK_IDLE;
      bw <= 24'd0;
      wp <= '0;
      done <= 1'b0;
      n <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      bw <= bw_next;
      wp <= wp_next;
      done <= done_next;
      n <= n_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/lz_flag_bit_decompressor_unit.sv */
// LZ flag-bit decompressor.
// Input channel (in_valid / in_stall / in_data): one compressed byte per item,
// with first_of_image marking the start of a new image. An item is taken on a
// rising edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall / out_data): up to four decoded bytes
// per item, with byte_count, last_of_run and status.
// Configuration: cfg_wr_en / cfg_wr_data write max_output_bytes.
// Flow: the parser takes one byte per cycle, while the two-entry command queue
// is not full, and pushes its commands into that queue. The executor passes
// each decoded byte through a history check state and a write state, so a
// literal goes from the queue through the IDLE, CHECK, WRITE and EMIT states
// to the output register; long copies hold in_stall high once the queue is full.
// Flag-word bytes and the low offset byte of a long copy produce no item.
// Reset (rst, synchronous) clears the parser, queue, executor and out_valid,
// and sets max_output_bytes to 614400. The history memory is not
// cleared: every read hits an entry written earlier in the same image.
// When the receiver stalls, the output item holds and the executor waits.
`default_nettype none
module lz_flag_bit_decompressor_unit #(
  parameter int unsigned WINDOW_DEPTH = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [23:0]         cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lzfd_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lzfd_pkg::out_item_t      out_data
);

  logic [23:0]    max_out;
  logic           f_valid;
  logic           q_ready;
  lzfd_pkg::cmd_t f_cmd;
  logic           q_valid;
  logic           q_pop;
  lzfd_pkg::cmd_t q_cmd;

  // hold the output limit; the user is to write it only while idle (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      max_out <= lzfd_pkg::MAX_OUT_RESET;
    end else if (cfg_wr_en) begin
      max_out <= cfg_wr_data;
    end
  end

  // parse flag bits and stream bytes into literal, copy and end commands
  lzfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (q_ready),
    .cmd       (f_cmd)
  );

  // decouple parser from executor
  lzfd_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_cmd  (f_cmd),
    .not_full  (q_ready),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_cmd)
  );

  // carry out commands against the history and pack output items
  lzfd_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .max_out   (max_out),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* rtl/core/lzfd_checker.sv */
`default_nettype none
module lzfd_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire lzfd_pkg::out_item_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output item dropped while stalled");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.byte_count <= 3'd4)
    else $error("byte count out of range");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != lzfd_pkg::ST_DATA |-> out_data.last_of_run)
    else $error("ending item not last of run");

  a_end_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == lzfd_pkg::ST_END |-> out_data.byte_count == 3'd0)
    else $error("end of image carries bytes");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_of_run |->
      out_data.byte_count == 3'd4 && out_data.status == lzfd_pkg::ST_DATA)
    else $error("partial item before end of run");

endmodule

bind lz_flag_bit_decompressor_unit lzfd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
